[rtl/dsd_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dsd_pkg
// Shared constants, types and the segment decoder for the decimal scanner.
// ---------------------------------------------------------------------------
package dsd_pkg;

   // Number of display positions in the cell chain.
   localparam int DIGITS = 8;
   // Width of a position index.
   localparam int POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   localparam int VALUE_W   = 32;
   localparam int BITCNT_W  = $clog2(VALUE_W);
   localparam int DWELL_W   = 16;
   localparam int SEL_W     = 3;
   localparam int SEG_W     = 8;
   localparam int BCD_W     = 4;

   // Item kinds carried on the request tuser bit.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Control strobes broadcast to every digit cell.
   typedef struct packed {
      logic clear;
      logic shift;
      logic commit;
   } dsd_cell_ctrl_type;

   // Common-cathode codes, bit 0 = segment a through bit 6 = segment g.
   function automatic logic [SEG_W-1:0] seg_encode(input logic [BCD_W-1:0] bcd);
      logic [SEG_W-1:0] seg;
      case (bcd)
         4'd0:    seg = 8'h3F;
         4'd1:    seg = 8'h06;
         4'd2:    seg = 8'h5B;
         4'd3:    seg = 8'h4F;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'h6D;
         4'd6:    seg = 8'h7D;
         4'd7:    seg = 8'h07;
         4'd8:    seg = 8'h7F;
         4'd9:    seg = 8'h6F;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage
`default_nettype wire

[rtl/dsd_digit_cell.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dsd_digit_cell
// One decimal digit of the shift-and-add-3 chain, plus its stored segment
// code and the leading-blank decision.
// ---------------------------------------------------------------------------
module dsd_digit_cell
   import dsd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dsd_cell_ctrl_type ctrl,
   input  wire logic              shift_in,   // carry from the less significant cell
   output logic                   shift_out,  // carry to the more significant cell
   input  wire logic              lit_in,     // a more significant digit is shown
   output logic                   lit_out,    // this digit or a higher one is shown
   output logic [SEG_W-1:0]       code
);

   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [SEG_W-1:0] code_ff, code_in;
   logic [BCD_W-1:0] adj;

   // Correct the digit before doubling so that it carries at ten.
   assign adj       = (bcd_ff >= 4'd5) ? bcd_ff + 4'd3 : bcd_ff;
   assign shift_out = adj[BCD_W-1];
   assign lit_out   = lit_in | (bcd_ff != '0);
   assign code      = code_ff;

   always_comb begin
      bcd_in = bcd_ff;
      if (ctrl.clear) begin
         bcd_in = '0;
      end else if (ctrl.shift) begin
         bcd_in = {adj[BCD_W-2:0], shift_in};
      end
   end

   always_comb begin
      code_in = code_ff;
      if (ctrl.commit) begin
         code_in = lit_out ? seg_encode(bcd_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
      if (reset) begin
         code_ff <= '0;
      end else begin
         code_ff <= code_in;
      end
   end

endmodule
`default_nettype wire

[rtl/seven_segment_decimal_scanner.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// seven_segment_decimal_scanner
// Multiplexed eight-digit seven-segment driver with a serial binary to
// decimal converter built from a chain of digit cells.
// ---------------------------------------------------------------------------
// Tick transaction: its result is registered and presented in the cycle after
// acceptance; ticks can be taken every cycle while the converter is idle and
// the result side keeps up. Load transaction: no result; nothing more is
// accepted until 32 shift steps through the digit cell chain and a commit step.
// Reset (synchronous, active high) blanks all digits, sets the scan position
// and dwell count to zero and the dwell length register to one.
// ---------------------------------------------------------------------------
module seven_segment_decimal_scanner
   import dsd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // Request stream.
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [VALUE_W-1:0]  req_tdata,   // [31:0] value
   input  wire logic                req_tuser,   // [0] kind: 0 load, 1 tick
   // Result stream.
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [15:0]              rsp_tdata,   // [2:0] digit_select, [10:3] segments
   // Dwell length register (ticks_per_digit).
   input  wire logic                csr_wen,
   input  wire logic [DWELL_W-1:0]  csr_wdata
);

   // The converter sequencer: idle, shifting the number in, then one cycle
   // in which every cell latches its segment code.
   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_CONV   = 3'b010,
      S_COMMIT = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_W-1:0]     value_ff, value_in;
   logic [BITCNT_W-1:0]    bitcnt_ff, bitcnt_in;
   logic                   ovf_ff, ovf_in;
   logic [DWELL_W-1:0]     tpd_ff, tpd_in;
   logic [DWELL_W-1:0]     dwell_ff, dwell_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SEL_W-1:0]       rsp_sel_ff, rsp_sel_in;
   logic [SEG_W-1:0]       rsp_seg_ff, rsp_seg_in;

   logic                   req_fire;
   logic                   load_fire;
   logic                   tick_fire;
   logic [DWELL_W-1:0]     dwell_inc;
   logic [DWELL_W-1:0]     limit;
   dsd_cell_ctrl_type      cell_ctrl;

   logic                   carry [DIGITS+1];
   logic                   lit   [DIGITS+1];
   logic [SEG_W-1:0]       cell_code [DIGITS];

   // A transaction is taken only while the converter is idle and the result
   // register is empty or being emptied in this cycle.
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign load_fire  = req_fire && (req_tuser == KIND_LOAD);
   assign tick_fire  = req_fire && (req_tuser == KIND_TICK);

   // Control strobes shared by every cell in the chain.
   assign cell_ctrl.clear  = load_fire;
   assign cell_ctrl.shift  = (state_ff == S_CONV);
   assign cell_ctrl.commit = (state_ff == S_COMMIT);

   // The binary number enters the least significant cell one bit per cycle,
   // most significant bit first. The blank decision ripples the other way:
   // a digit is lit when it or any higher digit is nonzero, or when the
   // number overflowed the chain, in which case every position is shown.
   assign carry[0]    = value_ff[VALUE_W-1];
   assign lit[DIGITS] = ovf_ff;

   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      dsd_digit_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .shift_in  (carry[i]),
         .shift_out (carry[i+1]),
         .lit_in    (lit[i+1]),
         .lit_out   (lit[i]),
         .code      (cell_code[DIGITS-1-i])
      );
   end

   // Sequencer for the conversion.
   always_comb begin
      state_in  = state_ff;
      value_in  = value_ff;
      bitcnt_in = bitcnt_ff;
      ovf_in    = ovf_ff;
      case (state_ff)
         S_IDLE: begin
            if (load_fire) begin
               state_in  = S_CONV;
               value_in  = req_tdata;
               bitcnt_in = BITCNT_W'(VALUE_W - 1);
               ovf_in    = 1'b0;
            end
         end
         S_CONV: begin
            value_in = {value_ff[VALUE_W-2:0], 1'b0};
            // A carry out of the top cell means the number has more digits
            // than the display; only the low digits are kept.
            ovf_in   = ovf_ff | carry[DIGITS];
            if (bitcnt_ff == '0) begin
               state_in = S_COMMIT;
            end else begin
               bitcnt_in = bitcnt_ff - 1'b1;
            end
         end
         S_COMMIT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Scan position and dwell counting. A zero dwell length acts as one.
   assign dwell_inc = dwell_ff + 1'b1;
   assign limit     = (tpd_ff == '0) ? DWELL_W'(1) : tpd_ff;

   always_comb begin
      dwell_in = dwell_ff;
      pos_in   = pos_ff;
      if (tick_fire) begin
         if (dwell_inc >= limit) begin
            dwell_in = '0;
            pos_in   = (pos_ff == POS_W'(DIGITS - 1)) ? '0 : pos_ff + 1'b1;
         end else begin
            dwell_in = dwell_inc;
         end
      end
   end

   // Dwell length register; a write leaves the dwell count alone.
   assign tpd_in = csr_wen ? csr_wdata : tpd_ff;

   // Result register: filled by a tick, emptied when the consumer takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sel_in   = rsp_sel_ff;
      rsp_seg_in   = rsp_seg_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (tick_fire) begin
         rsp_valid_in = 1'b1;
         rsp_sel_in   = SEL_W'(pos_ff);
         rsp_seg_in   = cell_code[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bitcnt_ff    <= '0;
         ovf_ff       <= 1'b0;
         tpd_ff       <= DWELL_W'(1);
         dwell_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bitcnt_ff    <= bitcnt_in;
         ovf_ff       <= ovf_in;
         tpd_ff       <= tpd_in;
         dwell_ff     <= dwell_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff   <= value_in;
      rsp_sel_ff <= rsp_sel_in;
      rsp_seg_ff <= rsp_seg_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_seg_ff, rsp_sel_ff};

   // The converter never takes a transaction while it is busy.
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("request accepted while converting");

   // A load always starts a conversion in the next cycle.
   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      load_fire |=> (state_ff == S_CONV))
      else $error("load did not start a conversion");

   // Every tick leaves a result in the output register.
   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      tick_fire |=> rsp_tvalid)
      else $error("tick gave no result");

   // The commit cycle lasts exactly one cycle.
   a_commit_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT) |=> (state_ff == S_IDLE))
      else $error("commit did not return to idle");

endmodule
`default_nettype wire
